FILE: sv/bcc_pkg.sv
// Shared types, codes and reset values for the button click classifier.
package bcc_pkg;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_DOWN = 2'd1,
      PH_UP   = 2'd2,
      PH_WAIT = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_CLICK    = 3'd1,
      EV_DOUBLE   = 3'd2,
      EV_LONG     = 3'd3,
      EV_LONG_REL = 3'd4,
      EV_CONT     = 3'd5,
      EV_CONT_REL = 3'd6
   } event_type;

   localparam int CsrIndexWidth = 8;
   localparam int CsrDataWidth  = 8;

   localparam logic [CsrIndexWidth-1:0] CSR_ACTIVE_LEVEL    = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_DEBOUNCE_TICKS  = 8'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_LONG_TICKS      = 8'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_DOUBLE_WINDOW   = 8'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_REPEAT_PERIOD   = 8'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_CONTINUOUS_MODE = 8'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_LONG_ON_RELEASE = 8'd6;
   localparam logic [CsrIndexWidth-1:0] CSR_DEFER_SINGLE    = 8'd7;

   localparam logic       RST_ACTIVE_LEVEL    = 1'b1;
   localparam logic [7:0] RST_DEBOUNCE_TICKS  = 8'd3;
   localparam logic [7:0] RST_LONG_TICKS      = 8'd50;
   localparam logic [7:0] RST_DOUBLE_WINDOW   = 8'd20;
   localparam logic [7:0] RST_REPEAT_PERIOD   = 8'd10;
   localparam logic       RST_CONTINUOUS_MODE = 1'b0;
   localparam logic       RST_LONG_ON_RELEASE = 1'b0;
   localparam logic       RST_DEFER_SINGLE    = 1'b0;

   localparam logic [7:0] HOLD_TOP = 8'hFF;

   typedef struct packed {
      logic       active_level;
      logic [7:0] debounce_ticks;
      logic [7:0] long_ticks;
      logic [7:0] double_window;
      logic [7:0] repeat_period;
      logic       continuous_mode;
      logic       long_on_release;
      logic       defer_single;
   } cfg_type;

endpackage

FILE: sv/bcc_csr.sv
// Configuration register file of the button click classifier.
module bcc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bcc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [bcc_pkg::CsrDataWidth-1:0]   csr_data,
   output bcc_pkg::cfg_type                   cfg
);

   bcc_pkg::cfg_type cfg_ff;
   bcc_pkg::cfg_type cfg_in;
   logic             write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (csr_index)
            bcc_pkg::CSR_ACTIVE_LEVEL:    cfg_in.active_level    = csr_data[0];
            bcc_pkg::CSR_DEBOUNCE_TICKS:  cfg_in.debounce_ticks  = csr_data;
            bcc_pkg::CSR_LONG_TICKS:      cfg_in.long_ticks      = csr_data;
            bcc_pkg::CSR_DOUBLE_WINDOW:   cfg_in.double_window   = csr_data;
            bcc_pkg::CSR_REPEAT_PERIOD:   cfg_in.repeat_period   = csr_data;
            bcc_pkg::CSR_CONTINUOUS_MODE: cfg_in.continuous_mode = csr_data[0];
            bcc_pkg::CSR_LONG_ON_RELEASE: cfg_in.long_on_release = csr_data[0];
            bcc_pkg::CSR_DEFER_SINGLE:    cfg_in.defer_single    = csr_data[0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_level    <= bcc_pkg::RST_ACTIVE_LEVEL;
         cfg_ff.debounce_ticks  <= bcc_pkg::RST_DEBOUNCE_TICKS;
         cfg_ff.long_ticks      <= bcc_pkg::RST_LONG_TICKS;
         cfg_ff.double_window   <= bcc_pkg::RST_DOUBLE_WINDOW;
         cfg_ff.repeat_period   <= bcc_pkg::RST_REPEAT_PERIOD;
         cfg_ff.continuous_mode <= bcc_pkg::RST_CONTINUOUS_MODE;
         cfg_ff.long_on_release <= bcc_pkg::RST_LONG_ON_RELEASE;
         cfg_ff.defer_single    <= bcc_pkg::RST_DEFER_SINGLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: sv/bcc_engine.sv
// Debounce counter and press phase machine, one tick per step.
module bcc_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                level,
   input  bcc_pkg::cfg_type    cfg,
   output bcc_pkg::event_type  event_code
);

   logic                stable_ff, stable_in;
   bcc_pkg::phase_type  phase_ff, phase_in;
   bcc_pkg::event_type  prev_ff, prev_in;
   bcc_pkg::event_type  pend_ff, pend_in;
   logic [7:0]          dbc_ff, dbc_in;
   logic [7:0]          hold_ff, hold_in;
   logic [7:0]          rep_ff, rep_in;
   logic [7:0]          gap_ff, gap_in;
   bcc_pkg::event_type  ev;

   always_comb begin
      stable_in = stable_ff;
      phase_in  = phase_ff;
      prev_in   = prev_ff;
      pend_in   = pend_ff;
      dbc_in    = dbc_ff;
      hold_in   = hold_ff;
      rep_in    = rep_ff;
      gap_in    = gap_ff;
      ev        = bcc_pkg::EV_NONE;

      if (level != stable_ff) begin
         dbc_in = dbc_ff + 8'd1;
         if (dbc_in >= cfg.debounce_ticks) begin
            stable_in = level;
            dbc_in    = 8'd0;
            if (phase_ff == bcc_pkg::PH_IDLE || phase_ff == bcc_pkg::PH_WAIT) begin
               phase_in = bcc_pkg::PH_DOWN;
            end else if (phase_ff == bcc_pkg::PH_DOWN) begin
               phase_in = bcc_pkg::PH_UP;
            end
         end
      end

      case (phase_in)
         bcc_pkg::PH_DOWN: begin
            if (stable_in == cfg.active_level) begin
               if (cfg.continuous_mode) begin
                  rep_in = rep_ff + 8'd1;
                  if (rep_in >= cfg.repeat_period) begin
                     rep_in  = 8'd0;
                     pend_in = bcc_pkg::EV_CONT;
                     ev      = bcc_pkg::EV_CONT;
                  end
               end else begin
                  if (pend_ff != bcc_pkg::EV_LONG) begin
                     pend_in = bcc_pkg::EV_CLICK;
                  end
                  hold_in = hold_ff + 8'd1;
                  if (hold_in >= cfg.long_ticks) begin
                     if (cfg.long_on_release) begin
                        pend_in = bcc_pkg::EV_LONG;
                     end else begin
                        rep_in = rep_ff + 8'd1;
                        if (rep_in >= cfg.repeat_period) begin
                           rep_in  = 8'd0;
                           pend_in = bcc_pkg::EV_LONG;
                           ev      = bcc_pkg::EV_LONG;
                        end
                     end
                     if (hold_in == bcc_pkg::HOLD_TOP) begin
                        hold_in = cfg.long_ticks;
                     end
                  end
               end
            end
         end
         bcc_pkg::PH_UP: begin
            if (pend_ff == bcc_pkg::EV_CLICK) begin
               if (gap_ff <= cfg.double_window && prev_ff == bcc_pkg::EV_DOUBLE) begin
                  pend_in  = bcc_pkg::EV_DOUBLE;
                  ev       = bcc_pkg::EV_DOUBLE;
                  phase_in = bcc_pkg::PH_IDLE;
                  prev_in  = bcc_pkg::EV_NONE;
               end else begin
                  gap_in  = 8'd0;
                  hold_in = 8'd0;
                  if (!cfg.defer_single) begin
                     ev = bcc_pkg::EV_CLICK;
                  end
                  phase_in = bcc_pkg::PH_WAIT;
                  prev_in  = bcc_pkg::EV_DOUBLE;
               end
            end else if (pend_ff == bcc_pkg::EV_LONG) begin
               ev       = cfg.long_on_release ? bcc_pkg::EV_LONG : bcc_pkg::EV_LONG_REL;
               hold_in  = 8'd0;
               phase_in = bcc_pkg::PH_IDLE;
               prev_in  = bcc_pkg::EV_LONG;
               pend_in  = bcc_pkg::EV_CLICK;
            end else if (cfg.continuous_mode && pend_ff == bcc_pkg::EV_CONT) begin
               hold_in  = 8'd0;
               ev       = bcc_pkg::EV_CONT_REL;
               phase_in = bcc_pkg::PH_IDLE;
               prev_in  = bcc_pkg::EV_CONT;
            end
         end
         bcc_pkg::PH_WAIT: begin
            gap_in = gap_ff + 8'd1;
            if (gap_in >= cfg.double_window) begin
               phase_in = bcc_pkg::PH_IDLE;
               prev_in  = bcc_pkg::EV_NONE;
            end
            if (cfg.defer_single && gap_in >= cfg.double_window &&
                prev_in != bcc_pkg::EV_CLICK) begin
               gap_in   = 8'd0;
               ev       = bcc_pkg::EV_CLICK;
               phase_in = bcc_pkg::PH_IDLE;
               prev_in  = bcc_pkg::EV_CLICK;
            end
         end
         default: begin
         end
      endcase
   end

   assign event_code = ev;

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= ~bcc_pkg::RST_ACTIVE_LEVEL;
         phase_ff  <= bcc_pkg::PH_IDLE;
         prev_ff   <= bcc_pkg::EV_NONE;
         pend_ff   <= bcc_pkg::EV_NONE;
         dbc_ff    <= 8'd0;
         hold_ff   <= 8'd0;
         rep_ff    <= 8'd0;
         gap_ff    <= 8'd0;
      end else if (step) begin
         stable_ff <= stable_in;
         phase_ff  <= phase_in;
         prev_ff   <= prev_in;
         pend_ff   <= pend_in;
         dbc_ff    <= dbc_in;
         hold_ff   <= hold_in;
         rep_ff    <= rep_in;
         gap_ff    <= gap_in;
      end
   end

   a_state_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(stable_ff) && $stable(phase_ff) && $stable(dbc_ff))
      else $error("engine state moved without a tick");

   a_debounce_below_limit: assert property (@(posedge clock) disable iff (reset)
      step && level != stable_ff && dbc_ff + 8'd1 >= cfg.debounce_ticks
      |=> stable_ff == $past(level) && dbc_ff == 8'd0)
      else $error("debounced level not taken");

endmodule

FILE: sv/button_click_classifier_core.sv
// Top level of the button click classifier: input stage, engine, result register.
//
// Takes one sampled button level per req transfer and returns exactly one event
// code per item on rsp, in order. One item is accepted every clock cycle while
// rsp is not stalled; each result passes through the input register, then the
// result register fed by the combinational debounce and phase update. Back
// pressure on rsp holds the result register and then the input register.
// Configuration writes on csr are always ready and take effect on the next tick.
module button_click_classifier_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] level, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [2:0] event_code, [7:3] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [bcc_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [bcc_pkg::CsrDataWidth-1:0]  csr_data
);

   bcc_pkg::cfg_type    cfg;
   bcc_pkg::event_type  event_code;
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_level_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_code_ff;
   logic                req_transfer;
   logic                advance;

   bcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bcc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .level      (s1_level_ff),
      .cfg        (cfg),
      .event_code (event_code)
   );

   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !s1_valid_ff || advance;
   assign req_transfer = req_tvalid && req_tready;
   assign s1_valid_in  = req_transfer || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_code_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         s1_level_ff <= req_tdata[0];
      end
      if (advance) begin
         rsp_code_ff <= event_code;
      end
   end

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("input stalled with room downstream");

   a_advance_fills_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff && rsp_code_ff == $past(event_code))
      else $error("result register missed a tick");

   a_code_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_code_ff != 3'd7)
      else $error("event code out of range");

endmodule
